// ===== rtl/vth_pkg.sv =====
// ----------------------------------------------------------------------------
// vth_pkg: shared types and constants for the vector-to-heading unit
// Holds the arctangent table, the gain constant and the inter-module
// structures of the CORDIC heading pipeline.
// ----------------------------------------------------------------------------
package vth_pkg;

  // Internal datapath width of the CORDIC magnitude and error terms.
  localparam int DataW = 60;
  // Angle accumulator width (binary angle plus guard and sign).
  localparam int AngW = 36;
  localparam int AzW = 22;
  localparam int IncW = 21;
  localparam int DecW = 3;
  localparam logic [31:0] Gain = 32'h9B74EDA8;

  function automatic logic [31:0] atan_turns(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
      3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
      6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
      9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
      12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
      15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
      18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
      21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
      24: t = 32'd41;        25: t = 32'd20;        26: t = 32'd10;
      27: t = 32'd5;         28: t = 32'd3;         29: t = 32'd1;
      30: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  function automatic logic [13:0] pow10(input logic [DecW-1:0] d);
    logic [13:0] p;
    case (d)
      3'd0: p = 14'd1;
      3'd1: p = 14'd10;
      3'd2: p = 14'd100;
      3'd3: p = 14'd1000;
      default: p = 14'd10000;
    endcase
    return p;
  endfunction

  // One CORDIC stage slot: error term, magnitude, angle accumulator.
  typedef struct packed {
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
    logic signed [AngW-1:0]  acc;
  } cordic_t;

  // Side data that rides along with each item.
  typedef struct packed {
    logic        zero;
    logic        horiz;
    logic [13:0] mult;
    logic signed [DataW-1:0] z;
    logic [AngW-1:0] az;
  } side_t;

endpackage

// ===== rtl/vth_stream_if.sv =====
// ----------------------------------------------------------------------------
// vth_stream_if: valid/ready channel
// Carries one item of a generic payload per handshake.
// ----------------------------------------------------------------------------
interface vth_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/vth_cordic.sv =====
// ----------------------------------------------------------------------------
// vth_cordic: pipelined CORDIC vectoring
// One register stage per iteration; advances when en is high.
// ----------------------------------------------------------------------------
module vth_cordic #(
  parameter int ITER = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  vth_pkg::cordic_t  in_data,
  input  vth_pkg::side_t    in_side,
  output logic              out_valid,
  output vth_pkg::cordic_t  out_data,
  output vth_pkg::side_t    out_side
);

  localparam int N = (ITER > 32) ? 32 : ITER;

  vth_pkg::cordic_t st [N+1];
  vth_pkg::side_t   sd [N+1];
  logic             vl [N+1];

  assign st[0] = in_data;
  assign sd[0] = in_side;
  assign vl[0] = in_valid;

  for (genvar i = 0; i < N; i++) begin : g_stage
    vth_pkg::cordic_t nx;
    // One micro-rotation toward a = 0.
    always_comb begin
      nx = st[i];
      if (!st[i].a[vth_pkg::DataW-1]) begin
        nx.b   = st[i].b + (st[i].a >>> i);
        nx.a   = st[i].a - (st[i].b >>> i);
        nx.acc = st[i].acc + $signed({4'd0, vth_pkg::atan_turns(i)});
      end else begin
        nx.b   = st[i].b - (st[i].a >>> i);
        nx.a   = st[i].a + (st[i].b >>> i);
        nx.acc = st[i].acc - $signed({4'd0, vth_pkg::atan_turns(i)});
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else if (en) begin
        vl[i+1] <= vl[i];
      end
      if (en) begin
        st[i+1] <= nx;
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_valid = vl[N];
  assign out_data  = st[N];
  assign out_side  = sd[N];

endmodule

// ===== rtl/vth_scale.sv =====
// ----------------------------------------------------------------------------
// vth_scale: binary angle to scaled decimal degrees
// Two register stages: product, then rounding and sign.
// ----------------------------------------------------------------------------
module vth_scale (
  input  logic              clk,
  input  logic              en,
  input  logic signed [vth_pkg::AngW-1:0] ang,
  input  logic [13:0]       mult,
  output logic signed [23:0] scaled
);

  logic [31:0] mag;
  logic        neg;
  logic [45:0] prod;
  logic        neg_q;
  logic [22:0] q;

  // Magnitude of the angle; its value is below 2^32.
  always_comb begin
    neg = ang[vth_pkg::AngW-1];
    mag = neg ? 32'(-ang) : 32'(ang);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= 46'(mag) * 46'(mult);
      neg_q <= neg;
    end
  end

  // Times 360 is (p << 8) + (p << 6) + (p << 5) + (p << 3).
  always_comb begin
    logic [56:0] p360;
    p360 = (57'(prod) << 8) + (57'(prod) << 6) + (57'(prod) << 5) + (57'(prod) << 3)
         + 57'h80000000;
    q = p360[54:32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scaled <= neg_q ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
  end

endmodule

// ===== rtl/vector_to_heading_unit.sv =====
// ----------------------------------------------------------------------------
// vector_to_heading_unit: azimuth and inclination of a 3D vector
// Usage:
//   Items enter on in_ch (comp_x, comp_y, comp_z, 24 bits signed each) and
//   leave on out_ch (azimuth_scaled, inclination_scaled, zero_vector), one
//   result for each item, in order. An item moves at a clock edge with valid
//   and ready both high.
//   The pipeline is an input register, a CORDIC for azimuth, a gain multiply,
//   a CORDIC for inclination, two scaling stages per angle and a clamped
//   output register (iterations capped at 32). The throughput is one item
//   per cycle while the receiver takes results. The depth of the two
//   unrolled CORDIC chains makes up most of the latency.
//   decimals is to be written with cfg_we/cfg_data only while idle, which
//   the block does not enforce; reset sets it to 3.
//   Reset (rst, synchronous) empties the pipeline.
//   When the receiver stalls the whole pipeline holds; the output register
//   keeps its item and in_ch.ready goes low while the output stays full.
// ----------------------------------------------------------------------------
module vector_to_heading_unit #(
  parameter int COMPONENT_WIDTH  = 24,
  parameter int ANGLE_ITERATIONS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_data,
  vth_stream_if.sink   in_ch,
  vth_stream_if.source out_ch
);

  localparam int DW = vth_pkg::DataW;
  localparam int SH = 56 - COMPONENT_WIDTH;

  logic [2:0] decimals;
  logic       en;
  logic       out_valid;

  // Whole pipeline advances unless the output holds an untaken item.
  assign en = !out_valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimals <= 3'd3;
    end else if (cfg_we) begin
      decimals <= cfg_data;
    end
  end

  // Input stage: scale, fold into right half plane.
  logic signed [COMPONENT_WIDTH-1:0] cx, cy, cz;
  logic signed [DW-1:0] x, y, z;
  logic [13:0]      mult1;
  vth_pkg::cordic_t c1_in;
  vth_pkg::side_t   s1_in;
  logic             v1;

  assign cx = in_ch.data[COMPONENT_WIDTH-1:0];
  assign cy = in_ch.data[2*COMPONENT_WIDTH-1:COMPONENT_WIDTH];
  assign cz = in_ch.data[3*COMPONENT_WIDTH-1:2*COMPONENT_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_ch.valid;
    end
    if (en) begin
      x <= DW'(cx) <<< SH;
      y <= DW'(cy) <<< SH;
      z <= DW'(cz) <<< SH;
      mult1 <= vth_pkg::pow10(decimals);
    end
  end

  always_comb begin
    c1_in.a   = y[DW-1] ? -x : x;
    c1_in.b   = y[DW-1] ? -y : y;
    c1_in.acc = y[DW-1] ? vth_pkg::AngW'(36'h080000000) : '0;
    s1_in.zero  = (x == '0) && (y == '0) && (z == '0);
    s1_in.horiz = (x != '0) || (y != '0);
    s1_in.mult  = mult1;
    s1_in.z     = z;
    s1_in.az    = '0;
  end

  // Azimuth CORDIC.
  logic             v2;
  vth_pkg::cordic_t c2;
  vth_pkg::side_t   s2;

  vth_cordic #(.ITER(ANGLE_ITERATIONS)) u_az (
    .clk, .rst, .en, .in_valid(v1), .in_data(c1_in), .in_side(s1_in),
    .out_valid(v2), .out_data(c2), .out_side(s2)
  );

  // Gain correction: two 32x32 partial products, registered.
  logic [63:0] hu;
  logic [63:0] p_hi, p_lo;
  logic        v3;
  vth_pkg::side_t s3;
  vth_pkg::side_t s3_next;

  assign hu = 64'(c2.b);

  // Side data with the azimuth angle taken from the first CORDIC.
  always_comb begin
    s3_next    = s2;
    s3_next.az = s2.horiz ? 36'(c2.acc[31:0]) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      p_hi  <= 64'(hu[63:32]) * 64'(vth_pkg::Gain);
      p_lo  <= 64'(hu[31:0]) * 64'(vth_pkg::Gain);
      s3    <= s3_next;
    end
  end

  vth_pkg::cordic_t c4_in;
  always_comb begin
    c4_in.a   = s3.z;
    c4_in.b   = s3.horiz ? DW'(p_hi + 64'(p_lo[63:32])) : '0;
    c4_in.acc = '0;
  end

  // Inclination CORDIC.
  logic             v4;
  vth_pkg::cordic_t c4;
  vth_pkg::side_t   s4;

  vth_cordic #(.ITER(ANGLE_ITERATIONS)) u_inc (
    .clk, .rst, .en, .in_valid(v3), .in_data(c4_in), .in_side(s3),
    .out_valid(v4), .out_data(c4), .out_side(s4)
  );

  // Scaling of both angles, two stages.
  logic signed [23:0] az_s, inc_s;
  logic               v5, v6;
  vth_pkg::side_t     s5, s6;

  vth_scale u_saz (.clk, .en, .ang($signed(s4.az)), .mult(s4.mult), .scaled(az_s));
  vth_scale u_sinc (.clk, .en, .ang(c4.acc), .mult(s4.mult), .scaled(inc_s));

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
      v6 <= v5;
    end
    if (en) begin
      s5 <= s4;
      s6 <= s5;
    end
  end

  // Clamp and output register.
  logic signed [23:0] lim;
  logic signed [23:0] inc_c;
  logic [vth_pkg::AzW-1:0]  az_o;
  logic [vth_pkg::IncW-1:0] inc_o;
  logic                     zero_o;

  always_comb begin
    lim = $signed(24'(s6.mult) * 24'sd90);
    inc_c = (inc_s > lim) ? lim : ((inc_s < -lim) ? -lim : inc_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v6;
    end
    if (en) begin
      zero_o <= s6.zero;
      az_o   <= s6.zero ? '0 : az_s[vth_pkg::AzW-1:0];
      inc_o  <= s6.zero ? '0 : inc_c[vth_pkg::IncW-1:0];
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = {zero_o, inc_o, az_o};

endmodule

// ===== rtl/vth_checker.sv =====
// ----------------------------------------------------------------------------
// vth_checker: port-level checks for the heading unit
// Watches handshakes and result ranges at the top level's ports.
// ----------------------------------------------------------------------------
module vth_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        in_ready,
  input logic [43:0] out_data
);

  // A pending result stays until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

  // Input is held off whenever a result waits.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during stall");

  // A zero vector yields zero angles.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[43] |-> out_data[42:0] == 43'd0)
    else $error("zero vector with nonzero angle");

  // Azimuth within 0 .. 3600000.
  a_az: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data[21:0] <= 22'd3600000)
    else $error("azimuth out of range");

endmodule

bind vector_to_heading_unit vth_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .in_ready(in_ch.ready), .out_data(out_ch.data)
);
